@@ rtl/core/stack_expression_evaluator_unit_assert.svh @@
// Assertion helpers shared by the RTL files.
`ifndef STACK_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SEE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("see assertion failed");

// next-cycle implication
`define SEE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("see assertion failed");

`endif

@@ rtl/core/see_pkg.sv @@
`default_nettype none
package see_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DATA_W + 1);
   localparam logic signed [DATA_W-1:0] SCREEN_SIZE = -DATA_W'(999);

   typedef enum logic [3:0] {
      CMD_PUSH      = 4'd0,
      CMD_FETCH     = 4'd1,
      CMD_ADD       = 4'd2,
      CMD_SUB       = 4'd3,
      CMD_MUL       = 4'd4,
      CMD_DIV       = 4'd5,
      CMD_MIN       = 4'd6,
      CMD_EQUAL     = 4'd7,
      CMD_SET_SIZE  = 4'd8,
      CMD_SIZE_X    = 4'd9,
      CMD_SIZE_Y    = 4'd10,
      CMD_SCREEN_W  = 4'd11,
      CMD_SCREEN_H  = 4'd12,
      CMD_WRITE_VAR = 4'd13,
      CMD_IF_TEST   = 4'd14
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_OPND,
      S_DIV_RUN,
      S_SIZE,
      S_REFILL_RD,
      S_REFILL,
      S_VAR_WAIT,
      S_RESP
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_EXEC,
      DP_BINARY,
      DP_DIV_START,
      DP_DIV_DONE,
      DP_SIZE,
      DP_REFILL,
      DP_VAR_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      show;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    sp_empty;
      logic    sp_lt2;
      logic    idx_ok;
      logic    top_zero;
      logic    div_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/see_if.sv @@
`default_nettype none
interface see_req_if;
   logic                valid;
   logic                ready;
   logic [3:0]          command;
   logic signed [31:0]  value;
   logic [8:0]          var_index;
   modport source (output valid, output command, output value, output var_index, input ready);
   modport sink   (input valid, input command, input value, input var_index, output ready);
endinterface

interface see_rsp_if #(parameter int DEPTH_W = 4);
   logic                valid;
   logic                ready;
   logic signed [31:0]  top_value;
   logic [DEPTH_W-1:0]  stack_depth;
   logic [1:0]          status;
   logic                sticky_error;
   logic                skip_next;
   modport source (output valid, output top_value, output stack_depth, output status,
                   output sticky_error, output skip_next, input ready);
   modport sink   (input valid, input top_value, input stack_depth, input status,
                   input sticky_error, input skip_next, output ready);
endinterface
`default_nettype wire

@@ rtl/core/see_ram.sv @@
`default_nettype none
module see_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/core/see_divider.sv @@
`default_nettype none
module see_divider
   import see_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   busy,
   output logic      [DATA_W-1:0] quotient
);
   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted, diff;

   // restoring division on magnitudes, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? -dividend : dividend;
         dvs_in  = divisor[DATA_W-1] ? -divisor : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = diff[DATA_W] ? shifted : diff;
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
endmodule
`default_nettype wire

@@ rtl/core/see_datapath.sv @@
`default_nettype none
`include "stack_expression_evaluator_unit_assert.svh"
module see_datapath
   import see_pkg::*;
#(
   parameter int STACK_ENTRIES = 10,
   parameter int VAR_ENTRIES   = 512,
   parameter int SPW           = $clog2(STACK_ENTRIES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         dp_cmd,
   output dp_stat_type             dp_stat,
   input  wire logic [3:0]         command,
   input  wire logic [DATA_W-1:0]  value,
   input  wire logic [8:0]         var_index,
   output logic      [DATA_W-1:0]  top_value,
   output logic      [SPW-1:0]     stack_depth,
   output status_type              status,
   output logic                    sticky_error,
   output logic                    skip_next
);
   localparam int SA = $clog2(STACK_ENTRIES);
   localparam int VA = $clog2(VAR_ENTRIES);

   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [8:0]        idx_ff, idx_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] dw_ff, dw_in;
   logic [DATA_W-1:0] dh_ff, dh_in;
   logic              err_ff, err_in;
   status_type        status_ff, status_in;
   logic              skip_ff, skip_in;

   logic              stk_we;
   logic [SA-1:0]     stk_waddr, stk_raddr;
   logic [DATA_W-1:0] stk_wdata, stk_rdata;
   logic              var_we;
   logic [DATA_W-1:0] var_rdata;
   logic              div_start, div_busy;
   logic [DATA_W-1:0] quotient;

   logic [SPW-1:0]    sp_m1, sp_m2;
   logic [DATA_W-1:0] push_val, alu_res, commit_val;
   logic              commit, sp_full, wr_idx_ok;

   assign sp_m1     = sp_ff - SPW'(1);
   assign sp_m2     = sp_ff - SPW'(2);
   assign sp_full   = (sp_ff == SPW'(STACK_ENTRIES));
   assign wr_idx_ok = ({23'd0, idx_ff} < 32'(VAR_ENTRIES));

   assign dp_stat.cmd      = cmd_ff;
   assign dp_stat.sp_empty = (sp_ff == '0);
   assign dp_stat.sp_lt2   = (sp_ff < SPW'(2));
   assign dp_stat.idx_ok   = !top_ff[DATA_W-1] && (top_ff < DATA_W'(VAR_ENTRIES));
   assign dp_stat.top_zero = (top_ff == '0);
   assign dp_stat.div_busy = div_busy;

   always_comb begin
      case (cmd_ff)
         CMD_SIZE_X:   push_val = dw_ff;
         CMD_SIZE_Y:   push_val = dh_ff;
         CMD_SCREEN_W: push_val = SCREEN_SIZE;
         CMD_SCREEN_H: push_val = SCREEN_SIZE;
         default:      push_val = val_ff;
      endcase
   end

   // a = second entry (just read), b = top
   always_comb begin
      case (cmd_ff)
         CMD_ADD:   alu_res = stk_rdata + top_ff;
         CMD_SUB:   alu_res = stk_rdata - top_ff;
         CMD_MUL:   alu_res = stk_rdata * top_ff;
         CMD_MIN:   alu_res = ($signed(stk_rdata) < $signed(top_ff)) ? stk_rdata : top_ff;
         CMD_EQUAL: alu_res = (stk_rdata == top_ff) ? '1 : '0;
         default:   alu_res = '0;   // divide by zero
      endcase
   end

   always_comb begin
      cmd_in     = cmd_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      sp_in      = sp_ff;
      top_in     = top_ff;
      dw_in      = dw_ff;
      dh_in      = dh_ff;
      status_in  = status_ff;
      skip_in    = skip_ff;
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[SA-1:0];
      stk_wdata  = push_val;
      stk_raddr  = sp_m1[SA-1:0];
      var_we     = 1'b0;
      div_start  = 1'b0;
      commit     = 1'b0;
      commit_val = alu_res;
      case (dp_cmd.op)
         DP_LOAD: begin
            cmd_in    = cmd_type'(command);
            val_in    = value;
            idx_in    = var_index;
            status_in = ST_OK;
            skip_in   = 1'b0;
         end
         DP_EXEC: begin
            case (cmd_ff)
               CMD_PUSH, CMD_SIZE_X, CMD_SIZE_Y, CMD_SCREEN_W, CMD_SCREEN_H: begin
                  if (sp_full) begin
                     status_in = ST_OVER;
                  end else begin
                     stk_we = 1'b1;
                     top_in = push_val;
                     sp_in  = sp_ff + SPW'(1);
                  end
               end
               CMD_FETCH: begin
                  if (dp_stat.sp_empty) begin
                     status_in = ST_UNDER;
                  end else begin
                     sp_in = sp_m1;
                  end
               end
               CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MIN, CMD_EQUAL: begin
                  stk_raddr = sp_m2[SA-1:0];
                  if (dp_stat.sp_lt2) begin
                     status_in = ST_UNDER;
                  end
               end
               CMD_SET_SIZE: begin
                  stk_raddr = sp_m2[SA-1:0];
                  if (dp_stat.sp_lt2) begin
                     sp_in     = '0;
                     status_in = ST_UNDER;
                  end
               end
               CMD_WRITE_VAR: begin
                  var_we = wr_idx_ok;
               end
               CMD_IF_TEST: begin
                  if (dp_stat.sp_empty) begin
                     status_in = ST_UNDER;
                  end else begin
                     skip_in = dp_stat.top_zero;
                     sp_in   = sp_m1;
                  end
               end
               default: begin
               end
            endcase
         end
         DP_BINARY: begin
            commit = 1'b1;
            if (cmd_ff == CMD_DIV) begin
               status_in = ST_DIVZ;
            end
         end
         DP_DIV_START: begin
            div_start = 1'b1;
         end
         DP_DIV_DONE: begin
            commit     = 1'b1;
            commit_val = quotient;
         end
         DP_SIZE: begin
            dw_in = stk_rdata;
            dh_in = top_ff;
            sp_in = sp_m2;
         end
         DP_REFILL: begin
            top_in = stk_rdata;
         end
         DP_VAR_PUSH: begin
            stk_we    = 1'b1;
            stk_wdata = var_rdata;
            top_in    = var_rdata;
            sp_in     = sp_ff + SPW'(1);
         end
         default: begin
         end
      endcase
      // result replaces the two operands
      if (commit) begin
         stk_we    = 1'b1;
         stk_waddr = sp_m2[SA-1:0];
         stk_wdata = commit_val;
         top_in    = commit_val;
         sp_in     = sp_m1;
      end
      err_in = err_ff | (status_in != ST_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         dw_ff     <= '0;
         dh_ff     <= '0;
         err_ff    <= 1'b0;
         status_ff <= ST_OK;
         skip_ff   <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         dw_ff     <= dw_in;
         dh_ff     <= dh_in;
         err_ff    <= err_in;
         status_ff <= status_in;
         skip_ff   <= skip_in;
      end
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      top_ff <= top_in;
   end

   see_ram #(.WIDTH(DATA_W), .DEPTH(STACK_ENTRIES)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   see_ram #(.WIDTH(DATA_W), .DEPTH(VAR_ENTRIES)) u_var_ram (
      .clock (clock),
      .we    (var_we),
      .waddr (VA'(idx_ff)),
      .wdata (val_ff),
      .raddr (top_ff[VA-1:0]),
      .rdata (var_rdata)
   );

   see_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stk_rdata),
      .divisor  (top_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign top_value    = dp_stat.sp_empty ? '0 : top_ff;
   assign stack_depth  = sp_ff;
   assign status       = status_ff;
   assign sticky_error = err_ff;
   assign skip_next    = skip_ff;

   `SEE_ASSERT_IMP(a_sp_range, clock, reset, 1'b1, sp_ff <= SPW'(STACK_ENTRIES))
   `SEE_ASSERT_NXT(a_err_sticky, clock, reset, err_ff, err_ff)
   `SEE_ASSERT_IMP(a_err_follows_status, clock, reset, status_ff != ST_OK, err_ff)
endmodule
`default_nettype wire

@@ rtl/core/see_ctrl.sv @@
`default_nettype none
`include "stack_expression_evaluator_unit_assert.svh"
module see_ctrl
   import see_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type dp_stat,
   output dp_cmd_type       dp_cmd
);
   ctrl_state_type state_ff, state_in;
   logic           div_go;

   assign div_go = (dp_stat.cmd == CMD_DIV) && !dp_stat.top_zero;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (dp_stat.cmd)
               CMD_FETCH: begin
                  if (dp_stat.sp_empty) begin
                     state_in = S_RESP;
                  end else if (dp_stat.idx_ok) begin
                     state_in = S_VAR_WAIT;
                  end else begin
                     state_in = S_REFILL_RD;
                  end
               end
               CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MIN, CMD_EQUAL: begin
                  state_in = dp_stat.sp_lt2 ? S_RESP : S_OPND;
               end
               CMD_SET_SIZE: begin
                  state_in = dp_stat.sp_lt2 ? S_RESP : S_SIZE;
               end
               CMD_IF_TEST: begin
                  state_in = dp_stat.sp_empty ? S_RESP : S_REFILL_RD;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_OPND: begin
            state_in = div_go ? S_DIV_RUN : S_RESP;
         end
         S_DIV_RUN: begin
            if (!dp_stat.div_busy) begin
               state_in = S_RESP;
            end
         end
         S_SIZE:      state_in = S_REFILL_RD;
         S_REFILL_RD: state_in = S_REFILL;
         S_REFILL:    state_in = S_RESP;
         S_VAR_WAIT:  state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.op   = DP_NONE;
      dp_cmd.show = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.op = DP_LOAD;
            end
         end
         S_EXEC:    dp_cmd.op = DP_EXEC;
         S_OPND:    dp_cmd.op = div_go ? DP_DIV_START : DP_BINARY;
         S_DIV_RUN: dp_cmd.op = dp_stat.div_busy ? DP_NONE : DP_DIV_DONE;
         S_SIZE:    dp_cmd.op = DP_SIZE;
         S_REFILL:  dp_cmd.op = DP_REFILL;
         S_VAR_WAIT: dp_cmd.op = DP_VAR_PUSH;
         S_RESP:    dp_cmd.show = 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_valid = dp_cmd.show;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SEE_ASSERT_NXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC)
   `SEE_ASSERT_NXT(a_deliver_idle, clock, reset, rsp_valid && rsp_ready, state_ff == S_IDLE)
   `SEE_ASSERT_IMP(a_div_only_run, clock, reset, dp_stat.div_busy, state_ff == S_DIV_RUN)
endmodule
`default_nettype wire

@@ rtl/core/stack_expression_evaluator_unit.sv @@
// Integer RPN stack calculator, one command per item.
// req_if: command, value, var_index; accepted when valid and ready are high.
// rsp_if: one result item per command: top_value (0 when empty), stack_depth,
//   status (ok/underflow/overflow/divide by zero), sticky_error, skip_next.
// One item is in flight at a time: ready is high only while the block is idle.
// From accept to response: push, write var, underflow and other one-step commands
//   respond after execute; add/sub/mul/min/equal and divide by zero pass an operand
//   step, a fetch that pushes a variable a variable-read step; if test and a fetch
//   whose index is out of range refetch the top from the stack RAM, set size does so
//   after storing the size; divide runs the 32-step serial divider; each ends in idle.
// The stack and variable stores are RAMs with a registered read port; the
//   top of stack is held in a register so most commands read the RAM at most once.
// Reset (synchronous, active high) empties the stack, clears the dialog size
//   and the sticky error; the RAM contents stay undefined until written.
// A stalled receiver holds the result: rsp stays valid and unchanged and no new
//   item is accepted until it is taken.
`default_nettype none
module stack_expression_evaluator_unit
   import see_pkg::*;
#(
   parameter int STACK_ENTRIES = 10,
   parameter int VAR_ENTRIES   = 512
) (
   input  wire logic  clock,
   input  wire logic  reset,
   see_req_if.sink    req_if,
   see_rsp_if.source  rsp_if
);
   localparam int SPW = $clog2(STACK_ENTRIES + 1);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   status_type  status;

   see_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // datapath: stack/variable RAMs, ALU, divider, status registers
   see_datapath #(
      .STACK_ENTRIES (STACK_ENTRIES),
      .VAR_ENTRIES   (VAR_ENTRIES),
      .SPW           (SPW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .dp_stat      (dp_stat),
      .command      (req_if.command),
      .value        (req_if.value),
      .var_index    (req_if.var_index),
      .top_value    (rsp_if.top_value),
      .stack_depth  (rsp_if.stack_depth),
      .status       (status),
      .sticky_error (rsp_if.sticky_error),
      .skip_next    (rsp_if.skip_next)
   );

   assign rsp_if.status = status;
endmodule
`default_nettype wire

@@ dv/stack_expression_evaluator_unit_tb.sv @@
`default_nettype none
module stack_expression_evaluator_unit_tb
   import see_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_N = 10;
   localparam int VAR_N   = 512;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [3:0]         stack_depth;
      logic [1:0]         status;
      logic               sticky_error;
      logic               skip_next;
   } calc_result_type;

   logic clock;
   logic reset;

   see_req_if req_if ();
   see_rsp_if #(.DEPTH_W(4)) rsp_if ();

   stack_expression_evaluator_unit #(
      .STACK_ENTRIES(STACK_N),
      .VAR_ENTRIES(VAR_N)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // predictor state
   logic [31:0]     calc_stack [STACK_N];
   int unsigned     calc_sp;
   logic [31:0]     calc_vars [VAR_N];
   bit              var_written [VAR_N];
   logic [31:0]     dlg_w, dlg_h;
   logic            err_latch;
   calc_result_type expected_results [$];

   int  error_count;
   int  send_idle_pct;
   int  recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit, far above the slowest correct run
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic status_type calc_push(logic [31:0] v);
      if (calc_sp >= STACK_N) return ST_OVER;
      calc_stack[calc_sp] = v;
      calc_sp++;
      return ST_OK;
   endfunction

   function automatic logic [31:0] calc_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, q;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q  = ua / ub;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   // advance the predicted machine by one command
   function automatic calc_result_type calc_step(logic [3:0] cmd, logic [31:0] val,
                                                 logic [8:0] vidx);
      calc_result_type r;
      status_type      st;
      logic [31:0]     a, b, res, idx;
      st = ST_OK;
      r  = '0;
      case (cmd)
         CMD_PUSH: st = calc_push(val);
         CMD_FETCH: begin
            if (calc_sp == 0) st = ST_UNDER;
            else begin
               calc_sp--;
               idx = calc_stack[calc_sp];
               if (!idx[31] && idx < VAR_N) st = calc_push(calc_vars[idx]);
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MIN, CMD_EQUAL: begin
            if (calc_sp < 2) st = ST_UNDER;
            else begin
               a = calc_stack[calc_sp-2];
               b = calc_stack[calc_sp-1];
               case (cmd)
                  CMD_ADD: res = a + b;
                  CMD_SUB: res = a - b;
                  CMD_MUL: res = a * b;
                  CMD_DIV: begin
                     if (b == 0) begin
                        res = '0;
                        st  = ST_DIVZ;
                     end else res = calc_div(a, b);
                  end
                  CMD_MIN: res = ($signed(a) < $signed(b)) ? a : b;
                  default: res = (a == b) ? '1 : '0;
               endcase
               calc_sp -= 2;
               calc_stack[calc_sp] = res;
               calc_sp++;
            end
         end
         CMD_SET_SIZE: begin
            if (calc_sp < 2) begin
               calc_sp = 0;
               st = ST_UNDER;
            end else begin
               dlg_w = calc_stack[calc_sp-2];
               dlg_h = calc_stack[calc_sp-1];
               calc_sp -= 2;
            end
         end
         CMD_SIZE_X: st = calc_push(dlg_w);
         CMD_SIZE_Y: st = calc_push(dlg_h);
         CMD_SCREEN_W, CMD_SCREEN_H: st = calc_push(SCREEN_SIZE);
         CMD_WRITE_VAR: begin
            if (vidx < VAR_N) begin
               calc_vars[vidx] = val;
               var_written[vidx] = 1'b1;
            end
         end
         CMD_IF_TEST: begin
            if (calc_sp == 0) st = ST_UNDER;
            else begin
               calc_sp--;
               r.skip_next = (calc_stack[calc_sp] == 0);
            end
         end
         default: ;
      endcase
      if (st != ST_OK) err_latch = 1'b1;
      r.top_value    = (calc_sp > 0) ? calc_stack[calc_sp-1] : '0;
      r.stack_depth  = calc_sp[3:0];
      r.status       = st;
      r.sticky_error = err_latch;
      return r;
   endfunction

   task automatic send_command(logic [3:0] cmd, logic [31:0] val = '0,
                               logic [8:0] vidx = '0);
      calc_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.command   <= cmd;
      req_if.value     <= val;
      req_if.var_index <= vidx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      r = calc_step(cmd, val, vidx);
      expected_results.push_back(r);
      // valid stays high into the next send; it drops only when the sender goes idle or drains
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // random ready, sampled at the rising edge
   always @(negedge clock) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      calc_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_if.top_value !== e.top_value) begin
               $error("top_value exp %0d got %0d", e.top_value, rsp_if.top_value);
               error_count++;
            end
            if (rsp_if.stack_depth !== e.stack_depth) begin
               $error("stack_depth exp %0d got %0d", e.stack_depth, rsp_if.stack_depth);
               error_count++;
            end
            if (rsp_if.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.sticky_error !== e.sticky_error) begin
               $error("sticky_error exp %0b got %0b", e.sticky_error, rsp_if.sticky_error);
               error_count++;
            end
            if (rsp_if.skip_next !== e.skip_next) begin
               $error("skip_next exp %0b got %0b", e.skip_next, rsp_if.skip_next);
               error_count++;
            end
         end
      end
   end

   // pick a slot already written, so fetches stay inside the contract
   function automatic int pick_written_var();
      int k;
      k = $urandom_range(VAR_N-1);
      for (int n = 0; n < VAR_N; n++)
         if (var_written[(k+n) % VAR_N]) return (k+n) % VAR_N;
      return -1;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         4: return $urandom_range(20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // directed: field extremes, every command, each corner case
   task automatic test_directed();
      send_command(CMD_IF_TEST);                 // underflow on empty stack
      send_command(CMD_FETCH);                   // underflow
      send_command(CMD_WRITE_VAR, 32'h8000_0000, 9'd0);
      send_command(CMD_WRITE_VAR, 32'h7fff_ffff, 9'd511);
      send_command(CMD_PUSH, 32'd511);
      send_command(CMD_FETCH);
      send_command(CMD_PUSH, 32'hffff_ffff);     // negative index: popped only
      send_command(CMD_FETCH);
      send_command(CMD_PUSH, 32'd512);           // index out of range
      send_command(CMD_FETCH);
      send_command(CMD_PUSH, 32'h8000_0000);
      send_command(CMD_PUSH, 32'hffff_ffff);
      send_command(CMD_DIV);                     // most negative / -1 wraps
      send_command(CMD_PUSH, 32'd0);
      send_command(CMD_DIV);                     // divide by zero
      send_command(CMD_SCREEN_W);
      send_command(CMD_SCREEN_H);
      send_command(CMD_SET_SIZE);
      send_command(CMD_SIZE_X);
      send_command(CMD_SIZE_Y);
      send_command(CMD_EQUAL);
      send_command(CMD_IF_TEST);                 // nonzero: no skip
      send_command(CMD_PUSH, 32'd0);
      send_command(CMD_IF_TEST);                 // zero: skip
      send_command(4'd15);                       // unused code
      for (int i = 0; i < 11; i++) send_command(CMD_SCREEN_W);  // overflow
      send_command(CMD_ADD);
      send_command(CMD_SUB);
      send_command(CMD_MUL);
      send_command(CMD_MIN);
      send_command(CMD_SET_SIZE);
      send_command(CMD_SET_SIZE);
      send_command(CMD_SET_SIZE);                // leaves the stack empty; the next one underflows
      send_command(CMD_SET_SIZE);
   endtask

   // mostly well-formed expressions with random operands, plus noise
   task automatic test_random(int count);
      int k;
      logic [3:0] cmd;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 30) send_command(CMD_PUSH, rand_word());
         else if (k < 40) send_command(CMD_WRITE_VAR, rand_word(), 9'($urandom));
         else if (k < 48) begin
            int v;
            v = pick_written_var();
            // full stack would drop the index and fetch an arbitrary entry
            if (calc_sp >= STACK_N) send_command(CMD_IF_TEST);
            if ($urandom_range(3) == 0) send_command(CMD_PUSH, $urandom_range(2000) + 512);
            else if (v >= 0) send_command(CMD_PUSH, v);
            else send_command(CMD_PUSH, -$urandom_range(100) - 1);
            send_command(CMD_FETCH);
         end else if (k < 54) send_command(CMD_DIV);
         else if (k < 90) begin
            cmd = 4'($urandom_range(CMD_SUB, CMD_IF_TEST));
            if (cmd == CMD_FETCH || cmd == CMD_WRITE_VAR) cmd = CMD_ADD;
            send_command(cmd, $urandom);
         end else if (k < 95) send_command(CMD_SCREEN_H);
         else begin
            cmd = 4'($urandom_range(15));
            // fetches only go through the guarded path above
            if (cmd == CMD_FETCH) cmd = CMD_IF_TEST;
            send_command(cmd, $urandom, 9'($urandom));
         end
      end
   endtask

   initial begin
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      calc_sp        = 0;
      dlg_w          = '0;
      dlg_h          = '0;
      err_latch      = 1'b0;
      foreach (var_written[i]) var_written[i] = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.command   = '0;
      req_if.value     = '0;
      req_if.var_index = '0;
      rsp_if.ready     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(200);
      wait_drained();                    // sender holds off until all results are in
      send_idle_pct = 57;
      test_random(200);
      send_idle_pct  = 0;
      recv_stall_pct = 57;
      test_random(200);
      send_idle_pct = 25;
      recv_stall_pct = 25;
      test_random(200);
      wait_drained();

      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/see_pkg.sv
rtl/core/see_if.sv
rtl/core/see_ram.sv
rtl/core/see_divider.sv
rtl/core/see_datapath.sv
rtl/core/see_ctrl.sv
rtl/core/stack_expression_evaluator_unit.sv
dv/stack_expression_evaluator_unit_tb.sv
